@@ hdl/thub_pkg.sv @@
package thub_pkg;

  // message kinds, same codes on the input and the output side
  localparam logic [2:0] K_NULL  = 3'd0;
  localparam logic [2:0] K_START = 3'd1;
  localparam logic [2:0] K_ADDR  = 3'd2;
  localparam logic [2:0] K_DATA  = 3'd3;
  localparam logic [2:0] K_ACK   = 3'd4;
  localparam logic [2:0] K_NACK  = 3'd5;
  localparam logic [2:0] K_CLK   = 3'd6;
  localparam logic [2:0] K_STOP  = 3'd7;

  localparam int MAX_LINKS_DEFAULT = 8;
  localparam int QUEUE_DEPTH       = 2;
  localparam logic [3:0] ACTIVE_LINKS_RESET = 4'd2;

  typedef struct packed {
    logic [2:0] source_link;
    logic [2:0] command;
    logic [7:0] address_byte;
    logic [7:0] data_byte;
  } thub_in_t;

  typedef struct packed {
    logic [7:0] target_mask;
    logic [2:0] out_kind;
    logic [7:0] out_address;
    logic [7:0] out_data;
  } thub_out_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] addr;
    logic [7:0] data;
  } thub_msg_t;

  // what an item does if it opens an exchange
  typedef enum logic [1:0] {
    CL_CLEAR,
    CL_XFER,
    CL_ADDR,
    CL_OTHER
  } thub_class_t;

  typedef struct packed {
    logic [2:0]  src;
    thub_msg_t   msg;
    thub_class_t cls;
    logic        is_nack;
    logic        addr_zero;
  } thub_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_LAST
  } thub_state_t;

  typedef struct packed {
    logic pop;
    logic rd_issue;
    logic load_arb;
  } thub_ctrl_t;

endpackage

@@ hdl/thub_front.sv @@
module thub_front (
  input  logic               valid,
  output logic               ready,
  input  thub_pkg::thub_in_t item,
  input  logic [3:0]         links,
  input  logic               q_full,
  output logic               push,
  output thub_pkg::thub_item_t push_item
);

  logic active;

  // senders at or above the link count are dropped here
  assign active = {1'b0, item.source_link} < links;
  assign ready  = !q_full;
  assign push   = valid && !q_full && active;

  always_comb begin
    push_item.src       = item.source_link;
    push_item.msg.kind  = item.command;
    push_item.msg.addr  = item.address_byte;
    push_item.msg.data  = item.data_byte;
    push_item.is_nack   = item.command == thub_pkg::K_NACK;
    push_item.addr_zero = item.address_byte == 8'h00;
    unique case (item.command) inside
      thub_pkg::K_START, thub_pkg::K_STOP: push_item.cls = thub_pkg::CL_CLEAR;
      thub_pkg::K_DATA, thub_pkg::K_CLK:   push_item.cls = thub_pkg::CL_XFER;
      thub_pkg::K_ADDR:                    push_item.cls = thub_pkg::CL_ADDR;
      default:                             push_item.cls = thub_pkg::CL_OTHER;
    endcase
  end

endmodule

@@ hdl/thub_queue.sv @@
module thub_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  thub_pkg::thub_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 valid,
  output thub_pkg::thub_item_t item
);

  localparam int QD = thub_pkg::QUEUE_DEPTH;
  localparam int PW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CW = $clog2(QD + 1);

  thub_pkg::thub_item_t slots [QD];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = count == CW'(QD);
  assign valid = count != '0;
  assign item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QD - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QD - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ hdl/thub_back.sv @@
module thub_back #(
  parameter int MAX_LINKS = thub_pkg::MAX_LINKS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [3:0]           links,
  input  logic                 q_valid,
  input  thub_pkg::thub_item_t item,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output thub_pkg::thub_out_t  out_item
);

  localparam int LW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;

  thub_pkg::thub_state_t state;
  thub_pkg::thub_state_t state_next;
  thub_pkg::thub_ctrl_t  ctrl;

  // link message store
  thub_pkg::thub_msg_t mem [MAX_LINKS];
  logic [MAX_LINKS-1:0] vld;
  thub_pkg::thub_msg_t rd_data;
  logic                rd_vld;

  // exchange state
  logic [2:0]          origin;
  logic [3:0]          expected;
  logic [3:0]          received;
  logic                gcall;
  logic [3:0]          gc_nacks;
  thub_pkg::thub_msg_t cmd;

  logic [2:0]          origin_next;
  logic [3:0]          expected_next;
  logic [3:0]          received_next;
  logic                gcall_next;
  logic [3:0]          gc_nacks_next;
  thub_pkg::thub_msg_t cmd_next;
  logic                complete;
  logic                opening;
  thub_pkg::thub_out_t open_res;

  // scan
  logic [LW-1:0]       scan_idx;
  logic                chk_valid;
  logic [LW-1:0]       chk_idx;
  logic                found;
  thub_pkg::thub_msg_t found_msg;
  logic [7:0]          min_data;
  logic                found_next;
  thub_pkg::thub_msg_t found_msg_next;
  logic [7:0]          min_data_next;
  thub_pkg::thub_msg_t chk_msg;
  thub_pkg::thub_out_t arb_res;
  logic                scan_done;

  thub_pkg::thub_out_t res;
  logic                res_valid;

  assign pop       = ctrl.pop;
  assign out_valid = res_valid;
  assign out_item  = res;
  assign scan_done = 4'(scan_idx) == links - 4'd1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      thub_pkg::BK_IDLE: if (ctrl.pop && !opening && complete) state_next = thub_pkg::BK_SCAN;
      thub_pkg::BK_SCAN: if (scan_done) state_next = thub_pkg::BK_LAST;
      thub_pkg::BK_LAST: state_next = thub_pkg::BK_IDLE;
      default:           state_next = thub_pkg::BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    ctrl = '0;
    unique case (state)
      thub_pkg::BK_IDLE: ctrl.pop      = q_valid && !res_valid;
      thub_pkg::BK_SCAN: ctrl.rd_issue = 1'b1;
      thub_pkg::BK_LAST: ctrl.load_arb = 1'b1;
      default:           ctrl = '0;
    endcase
  end

  // item execution against the exchange state
  always_comb begin
    logic signed [4:0] need;
    logic signed [4:0] need_new;
    thub_pkg::thub_msg_t cmd_after;
    logic gc_hit;
    need     = $signed({1'b0, expected}) - $signed({1'b0, gc_nacks});
    need_new = need;
    opening  = !($signed({1'b0, received}) < need);
    origin_next   = origin;
    expected_next = expected;
    received_next = received;
    gcall_next    = gcall;
    gc_nacks_next = gc_nacks;
    cmd_next      = cmd;
    complete      = 1'b0;
    for (int i = 0; i < 8; i++) begin
      open_res.target_mask[i] = (4'(i) < links) && (3'(i) != item.src);
    end
    open_res.out_kind    = item.msg.kind;
    open_res.out_address = item.msg.addr;
    open_res.out_data    = item.msg.data;
    cmd_after = (item.src == origin) ? item.msg : cmd;
    gc_hit    = (cmd_after.kind == thub_pkg::K_ADDR) && gcall && item.is_nack;
    if (opening) begin
      received_next = 4'd0;
      origin_next   = item.src;
      cmd_next      = item.msg;
      unique case (item.cls)
        thub_pkg::CL_CLEAR: begin
          gcall_next    = 1'b0;
          gc_nacks_next = 4'd0;
          expected_next = 4'd0;
        end
        thub_pkg::CL_XFER: expected_next = gcall ? links - 4'd1 : 4'd1;
        thub_pkg::CL_ADDR: begin
          gcall_next    = item.addr_zero;
          expected_next = links - 4'd1;
        end
        default: expected_next = 4'd0;
      endcase
    end else begin
      cmd_next      = cmd_after;
      gc_nacks_next = gc_hit ? gc_nacks + 4'd1 : gc_nacks;
      received_next = gc_hit ? received : received + 4'd1;
      need_new = $signed({1'b0, expected}) - $signed({1'b0, gc_nacks_next});
      complete = $signed({1'b0, received_next}) == need_new;
    end
  end

  // arbitration step on the registered read
  always_comb begin
    chk_msg        = rd_vld ? rd_data : '0;
    found_next     = found;
    found_msg_next = found_msg;
    min_data_next  = min_data;
    if (chk_valid && (4'(chk_idx) != 4'(origin))) begin
      if (chk_msg.kind == thub_pkg::K_ACK && !found) begin
        found_next     = 1'b1;
        found_msg_next = chk_msg;
      end
      if (chk_msg.data < min_data) begin
        min_data_next = chk_msg.data;
      end
    end
    arb_res.target_mask = 8'(8'd1 << origin);
    unique case (cmd.kind) inside
      thub_pkg::K_ADDR, thub_pkg::K_DATA: begin
        if (found_next) begin
          arb_res.out_kind    = found_msg_next.kind;
          arb_res.out_address = found_msg_next.addr;
          arb_res.out_data    = found_msg_next.data;
        end else begin
          arb_res.out_kind    = thub_pkg::K_NACK;
          arb_res.out_address = cmd.addr;
          arb_res.out_data    = 8'h00;
        end
      end
      thub_pkg::K_CLK: begin
        arb_res.out_kind    = thub_pkg::K_DATA;
        arb_res.out_address = 8'h00;
        arb_res.out_data    = min_data_next;
      end
      default: begin
        arb_res.out_kind    = thub_pkg::K_NULL;
        arb_res.out_address = 8'h00;
        arb_res.out_data    = 8'h00;
      end
    endcase
  end

  // store write and registered read
  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      mem[LW'(item.src)] <= item.msg;
    end
    if (ctrl.rd_issue) begin
      rd_data <= mem[scan_idx];
      rd_vld  <= vld[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= thub_pkg::BK_IDLE;
      vld       <= '0;
      origin    <= '0;
      expected  <= '0;
      received  <= '0;
      gcall     <= 1'b0;
      gc_nacks  <= '0;
      cmd       <= '0;
      res_valid <= 1'b0;
      chk_valid <= 1'b0;
      scan_idx  <= '0;
    end else begin
      state     <= state_next;
      chk_valid <= ctrl.rd_issue;
      if (ctrl.pop) begin
        vld[LW'(item.src)] <= 1'b1;
        origin   <= origin_next;
        expected <= expected_next;
        received <= received_next;
        gcall    <= gcall_next;
        gc_nacks <= gc_nacks_next;
        cmd      <= cmd_next;
        scan_idx <= '0;
      end else if (ctrl.rd_issue) begin
        scan_idx <= scan_idx + LW'(1);
      end
      if ((ctrl.pop && opening) || ctrl.load_arb) begin
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= scan_idx;
    if (ctrl.pop) begin
      found    <= 1'b0;
      min_data <= 8'hff;
    end else if (chk_valid) begin
      found     <= found_next;
      found_msg <= found_msg_next;
      min_data  <= min_data_next;
    end
    if (ctrl.pop && opening) begin
      res <= open_res;
    end else if (ctrl.load_arb) begin
      res <= arb_res;
    end
  end

endmodule

@@ hdl/twi_message_bus_hub_top.sv @@
// message-level twi hub: an opening message is broadcast via the result register; replies
// are absorbed at one per cycle while no result waits and no scan runs; the reply that
// completes an exchange is answered after the one-link-per-cycle arbitration scan
// a two-entry queue parts the front from the back, so input is taken while a result waits
// rst is synchronous, active high: link store reads as null messages, counters cleared,
// link count back to 2
module twi_message_bus_hub_top #(
  parameter int MAX_LINKS = thub_pkg::MAX_LINKS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  thub_pkg::thub_in_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output thub_pkg::thub_out_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_data
);

  localparam logic [4:0] MAXL = 5'(MAX_LINKS);

  // link count register and its saturated value
  logic [3:0] active_links;
  logic [3:0] links;

  // front to queue
  logic                 push;
  thub_pkg::thub_item_t push_item;
  logic                 q_full;

  // queue to back
  logic                 q_valid;
  logic                 pop;
  thub_pkg::thub_item_t q_item;

  // config transactions are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_links <= thub_pkg::ACTIVE_LINKS_RESET;
    end else if (cfg_valid) begin
      active_links <= cfg_data;
    end
  end

  // clamp to 2 .. MAX_LINKS
  always_comb begin
    if ({1'b0, active_links} < 5'd2) begin
      links = 4'd2;
    end else if ({1'b0, active_links} > MAXL) begin
      links = MAXL[3:0];
    end else begin
      links = active_links;
    end
  end

  // front: accept and classify, drop messages from inactive senders
  thub_front u_front (
    .valid     (in_valid),
    .ready     (in_ready),
    .item      (in_item),
    .links     (links),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // decoupling queue
  thub_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .valid     (q_valid),
    .item      (q_item)
  );

  // back: exchange state, link store, arbitration and result register
  thub_back #(
    .MAX_LINKS (MAX_LINKS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .links     (links),
    .q_valid   (q_valid),
    .item      (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

@@ test/twi_message_bus_hub_top_tb.sv @@
`timescale 1ns / 1ps

module twi_message_bus_hub_top_tb;

  localparam int MAX_LINKS    = thub_pkg::MAX_LINKS_DEFAULT;
  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 9;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 160;
  // answer delay grows with the link count and the two-entry queue, so this is plenty
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_CYCLES = 400;
  localparam longint LIMIT_NS = 5_000_000;

  // link-count settings per random phase, out-of-range values saturate
  int cfg_plan [PHASES] = '{8, 3, 15, 0, 6, 4, 1, 7, 5};

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  thub_pkg::thub_in_t  in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  thub_pkg::thub_out_t out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [3:0]          cfg_data = thub_pkg::ACTIVE_LINKS_RESET;

  // messages waiting to be offered, and answers the hub owes
  thub_pkg::thub_in_t  pending_msgs [$];
  thub_pkg::thub_out_t hub_answers [$];

  // shadow copy of the hub state
  logic [3:0]          links_cfg = thub_pkg::ACTIVE_LINKS_RESET;
  thub_pkg::thub_msg_t link_store [MAX_LINKS];
  logic [2:0]          exch_origin = '0;
  logic [3:0]          exch_expect = '0;
  logic [3:0]          exch_got = '0;
  logic                gc_flag = 1'b0;
  logic [3:0]          gc_nacks = '0;

  int errors = 0;
  int msgs_accepted = 0;
  int answers_checked = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_left = 0;
  int hs_seen = 0;

  twi_message_bus_hub_top #(
    .MAX_LINKS(MAX_LINKS)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  initial begin
    for (int i = 0; i < MAX_LINKS; i++) link_store[i] = '0;
  end

  task automatic report_error(input string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  // effective link count, saturated to 2..MAX_LINKS
  function automatic int link_count();
    int v;
    v = links_cfg;
    if (v < 2) v = 2;
    if (v > MAX_LINKS) v = MAX_LINKS;
    return v;
  endfunction

  // answer to the origin, chosen by the kind of its stored message
  function automatic thub_pkg::thub_msg_t pick_answer(input int n);
    thub_pkg::thub_msg_t cmd;
    thub_pkg::thub_msg_t rsp;
    cmd = link_store[exch_origin];
    rsp = '0;
    if (cmd.kind == thub_pkg::K_ADDR || cmd.kind == thub_pkg::K_DATA) begin
      // first ack wins, lowest link index
      rsp.kind = thub_pkg::K_NACK;
      rsp.addr = cmd.addr;
      for (int i = 0; i < n; i++) begin
        if (i != exch_origin && link_store[i].kind == thub_pkg::K_ACK) return link_store[i];
      end
    end else if (cmd.kind == thub_pkg::K_CLK) begin
      // clock read: the minimum of the other links' stored bytes is returned
      rsp.kind = thub_pkg::K_DATA;
      rsp.data = 8'hff;
      for (int i = 0; i < n; i++) begin
        if (i != exch_origin && link_store[i].data < rsp.data) rsp.data = link_store[i].data;
      end
    end
    return rsp;
  endfunction

  // advance the shadow state by one accepted message, queue the answer it causes
  task automatic hub_predict(input thub_pkg::thub_in_t it);
    int                  n;
    int                  need;
    thub_pkg::thub_msg_t m;
    thub_pkg::thub_msg_t a;
    thub_pkg::thub_out_t r;
    logic [15:0]         mask;
    n = link_count();
    // messages from links at or beyond the link count are dropped
    if (it.source_link >= n) return;
    m.kind = it.command;
    m.addr = it.address_byte;
    m.data = it.data_byte;
    need = int'(exch_expect) - int'(gc_nacks);
    if (int'(exch_got) < need) begin
      // reply to the open exchange
      link_store[it.source_link] = m;
      exch_got = exch_got + 4'd1;
      // nack to a general call is discounted
      if (link_store[exch_origin].kind == thub_pkg::K_ADDR && gc_flag &&
          m.kind == thub_pkg::K_NACK) begin
        gc_nacks = gc_nacks + 4'd1;
        exch_got = exch_got - 4'd1;
      end
      need = int'(exch_expect) - int'(gc_nacks);
      if (int'(exch_got) == need) begin
        mask = 16'd1 << exch_origin;
        a = pick_answer(n);
        r.target_mask = mask[7:0];
        r.out_kind    = a.kind;
        r.out_address = a.addr;
        r.out_data    = a.data;
        hub_answers.push_back(r);
      end
    end else begin
      // new exchange, broadcast to every other link
      exch_got = '0;
      exch_origin = it.source_link;
      link_store[it.source_link] = m;
      case (m.kind)
        thub_pkg::K_START, thub_pkg::K_STOP: begin
          gc_flag = 1'b0;
          gc_nacks = '0;
          exch_expect = '0;
        end
        thub_pkg::K_DATA, thub_pkg::K_CLK: begin
          exch_expect = gc_flag ? 4'(n - 1) : 4'd1;
        end
        thub_pkg::K_ADDR: begin
          gc_flag = (m.addr == 8'h00);
          exch_expect = 4'(n - 1);
        end
        default: begin
          exch_expect = '0;
        end
      endcase
      mask = ((16'd1 << n) - 16'd1) & ~(16'd1 << it.source_link);
      r.target_mask = mask[7:0];
      r.out_kind    = m.kind;
      r.out_address = m.addr;
      r.out_data    = m.data;
      hub_answers.push_back(r);
    end
  endtask

  // driver: one transaction at a time, valid held until accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        hub_predict(in_item);
        msgs_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_msgs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item <= pending_msgs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver hold-off: after some transactions, block the output long enough
  // to fill the hub queue while the driver keeps offering
  always @(posedge clk) begin
    if (rst) begin
      hs_seen <= 0;
      stall_left <= 0;
    end else begin
      if (in_valid && in_ready) hs_seen <= hs_seen + 1;
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
      end else if (in_valid && in_ready && (hs_seen == 300 || hs_seen == 1000)) begin
        stall_left <= STALL_CYCLES;
      end
    end
  end

  // monitor: each output transaction against the oldest owed answer
  always @(posedge clk) begin
    thub_pkg::thub_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (hub_answers.size() == 0) begin
          report_error($sformatf("unexpected answer %h", out_item));
        end else begin
          want = hub_answers.pop_front();
          answers_checked++;
          if (out_item.target_mask !== want.target_mask)
            report_error($sformatf("target_mask got %h want %h",
                                   out_item.target_mask, want.target_mask));
          if (out_item.out_kind !== want.out_kind)
            report_error($sformatf("out_kind got %0d want %0d",
                                   out_item.out_kind, want.out_kind));
          if (out_item.out_address !== want.out_address)
            report_error($sformatf("out_address got %h want %h",
                                   out_item.out_address, want.out_address));
          if (out_item.out_data !== want.out_data)
            report_error($sformatf("out_data got %h want %h",
                                   out_item.out_data, want.out_data));
        end
      end
      out_ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_msg(input int src, input logic [2:0] cmd,
                          input logic [7:0] addr, input logic [7:0] data);
    thub_pkg::thub_in_t it;
    it.source_link  = 3'(src);
    it.command      = cmd;
    it.address_byte = addr;
    it.data_byte    = data;
    pending_msgs.push_back(it);
  endtask

  // one exchange: opening message and replies from distinct other links;
  // returns how many messages the hub will not ignore
  task automatic queue_exchange(input int n, output int counted);
    int         origin;
    int         pick;
    int         replies;
    int         base;
    int         link;
    logic [2:0] kind;
    logic [2:0] rkind;
    logic [7:0] addr;
    origin = $urandom_range(n - 1);
    pick = $urandom_range(99);
    if (pick < 35)      kind = thub_pkg::K_ADDR;
    else if (pick < 55) kind = thub_pkg::K_DATA;
    else if (pick < 72) kind = thub_pkg::K_CLK;
    else if (pick < 80) kind = thub_pkg::K_START;
    else if (pick < 88) kind = thub_pkg::K_STOP;
    else                kind = 3'($urandom_range(7));
    addr = 8'($urandom_range(255));
    // general call now and then
    if (kind == thub_pkg::K_ADDR && $urandom_range(3) == 0) addr = 8'h00;
    case (kind)
      thub_pkg::K_ADDR:                  replies = n - 1;
      thub_pkg::K_DATA, thub_pkg::K_CLK: replies = ($urandom_range(1) == 0) ? 1 : n - 1;
      default:                           replies = 0;
    endcase
    // broken sequence: cut the replies short
    if (replies > 0 && $urandom_range(9) == 0) replies = $urandom_range(replies - 1);
    push_msg(origin, kind, addr, 8'($urandom_range(255)));
    counted = 1 + replies;
    base = $urandom_range(n - 2);
    for (int j = 0; j < replies; j++) begin
      link = (origin + 1 + ((base + j) % (n - 1))) % n;
      pick = $urandom_range(9);
      if (kind == thub_pkg::K_CLK) rkind = (pick < 8) ? thub_pkg::K_DATA : 3'($urandom_range(7));
      else if (pick < 5)           rkind = thub_pkg::K_ACK;
      else if (pick < 9)           rkind = thub_pkg::K_NACK;
      else                         rkind = 3'($urandom_range(7));
      push_msg(link, rkind, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_msgs.size() != 0 || in_valid || hub_answers.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_links(input int v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= 4'(v);
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    links_cfg = 4'(v);
  endtask

  initial begin : stimulus
    int n;
    int sent;
    int got;
    int src;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset link count of two
    send_idle_pct = 17;
    recv_idle_pct = 88;
    push_msg(0, thub_pkg::K_START, 8'h00, 8'h00);
    push_msg(1, thub_pkg::K_NULL,  8'hff, 8'hff);
    // plain address, acked
    push_msg(0, thub_pkg::K_ADDR,  8'ha4, 8'h00);
    push_msg(1, thub_pkg::K_ACK,   8'h00, 8'hff);
    // general call, nack discounted
    push_msg(1, thub_pkg::K_ADDR,  8'h00, 8'h55);
    push_msg(0, thub_pkg::K_NACK,  8'hff, 8'hff);
    // data under general call; the old discounted nack means no reply is owed
    push_msg(0, thub_pkg::K_DATA,  8'h12, 8'h34);
    push_msg(1, thub_pkg::K_NACK,  8'h00, 8'h00);
    // clock read, again with no reply owed while the general call lasts
    push_msg(0, thub_pkg::K_CLK,   8'h00, 8'h00);
    push_msg(1, thub_pkg::K_DATA,  8'h00, 8'h7e);
    // senders above the link count are ignored
    push_msg(5, thub_pkg::K_DATA,  8'hff, 8'hff);
    push_msg(7, thub_pkg::K_ACK,   8'h00, 8'h00);
    push_msg(1, thub_pkg::K_STOP,  8'hff, 8'h00);
    push_msg(0, thub_pkg::K_ACK,   8'h80, 8'h01);
    push_msg(0, thub_pkg::K_NACK,  8'h01, 8'h80);
    // clock read with all ones
    push_msg(1, thub_pkg::K_CLK,   8'hff, 8'hff);
    push_msg(0, thub_pkg::K_DATA,  8'h00, 8'hff);
    // address nacked outside general call
    push_msg(1, thub_pkg::K_ADDR,  8'hff, 8'hff);
    push_msg(0, thub_pkg::K_NACK,  8'h5a, 8'ha5);
    // data acked
    push_msg(0, thub_pkg::K_DATA,  8'hff, 8'h00);
    push_msg(1, thub_pkg::K_ACK,   8'hff, 8'hff);
    wait_drained();

    // random phases, idling: sender light then receiver light then none
    for (int p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        send_idle_pct = 17;
        recv_idle_pct = 88;
      end else if (p < 6) begin
        send_idle_pct = 88;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_links(cfg_plan[p]);
      n = link_count();
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(9) < 8) begin
          queue_exchange(n, got);
          sent += got;
        end else begin
          // noise, may come from an absent link
          src = $urandom_range(MAX_LINKS - 1);
          push_msg(src, 3'($urandom_range(7)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
          if (src < n) sent++;
        end
      end
      wait_drained();
    end

    $display("covered %0d transactions in, %0d answers checked, %0d link-count settings",
             msgs_accepted, answers_checked, PHASES + 1);
    $display("includes general calls, clock reads, ignored senders and a stalled output");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog against a hung handshake
  initial begin
    #(LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
